[sv/cmf_pkg.sv]
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared types and constants for the color matrix pixel filter.
// ----------------------------------------------------------------------------
package cmf_pkg;

  localparam int unsigned ChanW   = 8;   // one color channel
  localparam int unsigned LaneW   = 16;  // one packed coefficient or offset
  localparam int unsigned RowW    = 4 * LaneW;
  localparam int unsigned QuotW   = 16;  // unpremultiplied level, up to 65025
  localparam int unsigned DivStep = 4;   // quotient bits resolved per stage
  localparam int unsigned DivStg  = QuotW / DivStep;
  localparam int unsigned CfgAw   = 3;

  typedef enum logic [CfgAw-1:0] {
    REG_RED_ROW   = 3'd0,
    REG_GREEN_ROW = 3'd1,
    REG_BLUE_ROW  = 3'd2,
    REG_ALPHA_ROW = 3'd3,
    REG_OFFSETS   = 3'd4,
    REG_OPAQUE    = 3'd5
  } cfg_reg_e;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [QuotW-1:0] quot_t;

endpackage

[sv/cmf_div.sv]
// ----------------------------------------------------------------------------
// cmf_div
// Pipelined restoring divider, 16-bit dividend by 8-bit divisor.
// ----------------------------------------------------------------------------
module cmf_div (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  cmf_pkg::quot_t       numer_i,
  input  cmf_pkg::chan_t       denom_i,
  output cmf_pkg::quot_t       quot_o
);
  import cmf_pkg::*;

  chan_t rem_q [DivStg];
  quot_t quo_q [DivStg];
  quot_t num_q [DivStg];
  chan_t den_q [DivStg];

  // four restoring steps on an 8-bit remainder
  function automatic logic [ChanW+DivStep-1:0] step(input chan_t rem,
                                                    input logic [DivStep-1:0] nib,
                                                    input chan_t den);
    logic [ChanW:0]       r;
    logic [DivStep-1:0]   q;
    chan_t                rr;
    rr = rem;
    q  = '0;
    for (int i = DivStep - 1; i >= 0; i--) begin
      r = {rr, nib[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
      rr = r[ChanW-1:0];
    end
    return {rr, q};
  endfunction

  for (genvar s = 0; s < DivStg; s++) begin : g_stg
    chan_t               rem_in;
    quot_t               quo_in;
    quot_t               num_in;
    chan_t               den_in;
    logic [ChanW+DivStep-1:0] res;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = numer_i;
      assign den_in = denom_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign res = step(rem_in, num_in[QuotW-1-DivStep*s -: DivStep], den_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= res[ChanW+DivStep-1:DivStep];
        quo_q[s] <= quo_in | (quot_t'(res[DivStep-1:0]) << (QuotW - DivStep*(s+1)));
        num_q[s] <= num_in;
        den_q[s] <= den_in;
      end
    end
  end

  assign quot_o = quo_q[DivStg-1];

endmodule

[sv/color_matrix_pixel_filter.sv]
// ----------------------------------------------------------------------------
// color_matrix_pixel_filter
// 4x4 color matrix plus offsets on premultiplied 8-bit RGBA pixels.
// ----------------------------------------------------------------------------
// Takes one premultiplied RGBA pixel per clock and returns one filtered pixel
// per clock, in and out, for as long as the sink keeps tready high. Each
// word passes the dividend stage, the unpremultiply divider (four stages,
// four quotient bits each), then multiply, sum, round/clamp, premultiply
// and divide-by-255 stages. The whole pipeline stalls together when the
// output word is not taken. Configuration is written through cfg_* (always
// ready) and must only change while the pipeline is empty. Register
// indexes: 0..3 matrix rows r,g,b,a (four signed 16-bit lanes,
// COEF_FRAC_BITS fraction bits, lane 0 weights red), 4 offsets (signed, 6
// fraction bits), 5 source opaque flag. Other indexes are ignored.
// ----------------------------------------------------------------------------
module color_matrix_pixel_filter #(
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input pixel stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // red_in, green_in, blue_in, alpha_in
  // output pixel stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // red_out, green_out, blue_out, alpha_out
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [cmf_pkg::CfgAw-1:0] cfg_addr_i,
  input  logic [63:0] cfg_data_i
);
  import cmf_pkg::*;

  localparam int unsigned NStg  = 10;      // pipeline depth
  localparam int unsigned ProdW = 33;      // 16s x 17s
  localparam int unsigned AccW  = 36;      // five terms
  localparam int unsigned TW    = 16;      // y*a + 127
  localparam logic [16:0] Recip255 = 17'd32897;  // ceil(2^23/255)

  // ---------------- configuration ----------------
  logic [RowW-1:0] row_q [4];
  logic [RowW-1:0] off_q;
  logic            opq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) begin
        row_q[r] <= RowW'(1) << (COEF_FRAC_BITS + LaneW * r);
      end
      off_q <= '0;
      opq_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_RED_ROW:   row_q[0] <= cfg_data_i;
        REG_GREEN_ROW: row_q[1] <= cfg_data_i;
        REG_BLUE_ROW:  row_q[2] <= cfg_data_i;
        REG_ALPHA_ROW: row_q[3] <= cfg_data_i;
        REG_OFFSETS:   off_q    <= cfg_data_i;
        REG_OPAQUE:    opq_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // skip premultiply when opaque and alpha row passes alpha through untouched
  logic keep_opq;
  assign keep_opq = opq_q &&
                    row_q[3][47:0] == '0 &&
                    row_q[3][63:48] == LaneW'(1 << COEF_FRAC_BITS) &&
                    off_q[63:48] == '0;

  // ---------------- stall control ----------------
  logic [NStg-1:0] vld_q;
  logic            en;

  assign en              = !vld_q[NStg-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid_i};
    end
  end

  // ---------------- stage 0: dividend c*255 + a/2 ----------------
  logic [31:0] pix_q [DivStg+1];   // raw pixel riding alongside the divider
  quot_t       num_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_q[0] <= s_axis_tdata_i;
      for (int c = 0; c < 3; c++) begin
        num_q[c] <= (quot_t'(s_axis_tdata_i[8*c +: 8]) << 8)
                    - quot_t'(s_axis_tdata_i[8*c +: 8])
                    + quot_t'(s_axis_tdata_i[31:25]);
      end
      for (int k = 1; k <= DivStg; k++) begin
        pix_q[k] <= pix_q[k-1];
      end
    end
  end

  // ---------------- stages 1..4: unpremultiply divide ----------------
  quot_t quo [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    cmf_div u_div (
      .clk_i   (clk_i),
      .en_i    (en),
      .numer_i (num_q[c]),
      .denom_i (pix_q[0][31:24]),
      .quot_o  (quo[c])
    );
  end

  // ---------------- stage 5: products ----------------
  quot_t                    x [4];
  logic signed [ProdW-1:0]  prod_q [4][4];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (opq_q)                       x[c] = quot_t'(pix_q[DivStg][8*c +: 8]);
      else if (pix_q[DivStg][31:24] == '0) x[c] = '0;
      else                             x[c] = quo[c];
    end
    x[3] = quot_t'(pix_q[DivStg][31:24]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int j = 0; j < 4; j++) begin
          prod_q[r][j] <= ProdW'($signed(row_q[r][LaneW*j +: LaneW]) *
                                 $signed({1'b0, x[j]}));
        end
      end
    end
  end

  // ---------------- stage 6: row sums ----------------
  logic signed [AccW-1:0] acc_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        acc_q[r] <= (AccW'($signed(off_q[LaneW*r +: LaneW])) <<< (COEF_FRAC_BITS - 6))
                    + AccW'(prod_q[r][0]) + AccW'(prod_q[r][1])
                    + AccW'(prod_q[r][2]) + AccW'(prod_q[r][3]);
      end
    end
  end

  // ---------------- stage 7: round half up, clamp ----------------
  chan_t y_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        logic [AccW-1:0] v;
        v = (AccW'(acc_q[r]) + (AccW'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
        if (acc_q[r][AccW-1])         y_q[r] <= '0;
        else if (v > AccW'(255))      y_q[r] <= 8'd255;
        else                          y_q[r] <= v[ChanW-1:0];
      end
    end
  end

  // ---------------- stage 8: premultiply product ----------------
  logic [TW-1:0] t_q [3];
  chan_t         yk_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        t_q[c] <= TW'(y_q[c] * y_q[3]) + TW'(127);
      end
      yk_q <= y_q;
    end
  end

  // ---------------- stage 9: divide by 255, output word ----------------
  logic [31:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        logic [TW+16:0] p;
        p = (TW+17)'(t_q[c]) * (TW+17)'(Recip255);
        out_q[8*c +: 8] <= keep_opq ? yk_q[c] : p[30:23];
      end
      out_q[31:24] <= yk_q[3];
    end
  end

  assign m_axis_tdata_o = out_q;

endmodule

[sv/cmf_checker.sv]
// ----------------------------------------------------------------------------
// cmf_checker
// Port-level checks for the color matrix pixel filter.
// ----------------------------------------------------------------------------
module cmf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  // stalled output word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word dropped or changed while stalled");

  // input side only stalls when the output word is stuck
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stall");

  // output valid only drops after the word was taken
  a_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid_o) |-> $past(m_axis_tready_i))
    else $error("output word vanished without handshake");

  // the input side only stalls while an output word is waiting
  a_nogrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output");

endmodule

bind color_matrix_pixel_filter cmf_checker u_cmf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[test/color_matrix_pixel_filter_tb.sv]
// ----------------------------------------------------------------------------
// color_matrix_pixel_filter_tb
// Self-checking bench for the color matrix pixel filter.
// ----------------------------------------------------------------------------
// Pixels go in on the input stream with random gaps; results leave on the
// output stream under random back-pressure. A behavioral model of the
// unpremultiply / matrix / clamp / premultiply path predicts every output
// word, which is compared field by field in arrival order. The run walks a
// table of directed pixels under the identity rows, then directed pixels
// under extreme rows, then random pixels over several register setups.
// Registers only change with the pipeline drained.
// ----------------------------------------------------------------------------
module color_matrix_pixel_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cmf_pkg::*;

  localparam int unsigned FracBits = 12;
  localparam int unsigned DrainCycles = 30;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // red_in, green_in, blue_in, alpha_in
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // red_out, green_out, blue_out, alpha_out
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CfgAw-1:0] cfg_addr_i;
  logic [63:0] cfg_data_i;

  color_matrix_pixel_filter #(.COEF_FRAC_BITS(FracBits)) uut (.*);

  typedef struct packed {
    chan_t a;
    chan_t b;
    chan_t g;
    chan_t r;
  } pixel_t;

  // Filter setup mirrored on the bench side
  logic [63:0] row_coef [4];
  logic [63:0] offsets;
  logic        opaque_src;

  pixel_t pending_pixels[$];
  int     errors;
  int     words_in;
  int     words_out;

  // Directed rows; exp_valid marks results readable at a glance
  typedef struct {
    pixel_t pix;
    bit     exp_valid;
    pixel_t exp;
  } vector_t;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint lane(logic [63:0] w, int k);
    return longint'($signed(w[16*k +: 16]));
  endfunction

  // Predicted output pixel for the current setup
  function automatic pixel_t filter_pixel(pixel_t p);
    longint x [4];
    longint y [4];
    longint acc;
    bit     alpha_ident;
    pixel_t o;
    x[0] = p.r;
    x[1] = p.g;
    x[2] = p.b;
    x[3] = p.a;
    if (!opaque_src) begin
      for (int i = 0; i < 3; i++)
        x[i] = (p.a == 0) ? 0 : (x[i] * 255 + p.a / 2) / p.a;
    end
    for (int i = 0; i < 4; i++) begin
      acc = lane(offsets, i) <<< (FracBits - 6);
      for (int j = 0; j < 4; j++) acc += lane(row_coef[i], j) * x[j];
      if (acc < 0) y[i] = 0;
      else begin
        y[i] = (acc + (longint'(1) << (FracBits - 1))) >>> FracBits;
        if (y[i] > 255) y[i] = 255;
      end
    end
    alpha_ident = lane(row_coef[3], 0) == 0 && lane(row_coef[3], 1) == 0 &&
                  lane(row_coef[3], 2) == 0 &&
                  lane(row_coef[3], 3) == (longint'(1) << FracBits) &&
                  lane(offsets, 3) == 0;
    if (!(opaque_src && alpha_ident)) begin
      for (int i = 0; i < 3; i++) y[i] = (y[i] * y[3] + 127) / 255;
    end
    o.r = y[0][7:0];
    o.g = y[1][7:0];
    o.b = y[2][7:0];
    o.a = y[3][7:0];
    return o;
  endfunction

  // One register write; valid drops again on the config channel before return
  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_RED_ROW:   row_coef[0] = val;
      REG_GREEN_ROW: row_coef[1] = val;
      REG_BLUE_ROW:  row_coef[2] = val;
      REG_ALPHA_ROW: row_coef[3] = val;
      REG_OFFSETS:   offsets = val;
      REG_OPAQUE:    opaque_src = val[0];
      default: ;
    endcase
  endtask

  // Random gap, then one word on the input stream; valid stays up for a
  // back-to-back word, wait_drained drops it
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= p;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_pixels.push_back(filter_pixel(p));
    words_in++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    s_axis_tvalid_i <= 1'b0;
    while (pending_pixels.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Small random coefficient near the useful range (about -2.0..2.0)
  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h1000;
      2: return 16'(int'($urandom_range(0, 16384)) - 8192);
      default: return 16'(int'($urandom_range(0, 4096)) - 1024);
    endcase
  endfunction

  // Output side: random stalls, compare with oldest prediction
  initial begin
    pixel_t got;
    pixel_t want;
    int     stall;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o;
        words_out++;
        if (pending_pixels.size() == 0) begin
          $error("unexpected output word %h", got);
          errors++;
        end else begin
          want = pending_pixels.pop_front();
          if (got.r !== want.r) begin
            $error("red_out expected %0d got %0d", want.r, got.r); errors++;
          end
          if (got.g !== want.g) begin
            $error("green_out expected %0d got %0d", want.g, got.g); errors++;
          end
          if (got.b !== want.b) begin
            $error("blue_out expected %0d got %0d", want.b, got.b); errors++;
          end
          if (got.a !== want.a) begin
            $error("alpha_out expected %0d got %0d", want.a, got.a); errors++;
          end
        end
        // hold ready for a burst sometimes, else draw a stall
        stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
        if (stall != 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
          m_axis_tready_i <= 1'b1;
        end
      end else if (!m_axis_tready_i) begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    vector_t vecs [$];
    vector_t v;
    pixel_t  p;
    pixel_t  chk;
    int      setup;
    errors = 0;
    words_in = 0;
    words_out = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = REG_RED_ROW;
    cfg_data_i = '0;
    row_coef[0] = 64'h1 << FracBits;
    row_coef[1] = 64'h1 << (FracBits + 16);
    row_coef[2] = 64'h1 << (FracBits + 32);
    row_coef[3] = 64'h1 << (FracBits + 48);
    offsets = '0;
    opaque_src = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset: identity; opaque pixels pass, zero alpha clears colors
    vecs.push_back('{pixel_t'({8'd255, 8'd255, 8'd255, 8'd255}), 1,
                     pixel_t'({8'd255, 8'd255, 8'd255, 8'd255})});
    vecs.push_back('{pixel_t'({8'd0, 8'd0, 8'd0, 8'd0}), 1,
                     pixel_t'({8'd0, 8'd0, 8'd0, 8'd0})});
    vecs.push_back('{pixel_t'({8'd0, 8'd200, 8'd100, 8'd50}), 1,
                     pixel_t'({8'd0, 8'd0, 8'd0, 8'd0})});
    vecs.push_back('{pixel_t'({8'd255, 8'd10, 8'd20, 8'd30}), 1,
                     pixel_t'({8'd255, 8'd10, 8'd20, 8'd30})});
    // colors above alpha (invalid premultiplied), odd alphas
    vecs.push_back('{pixel_t'({8'd1, 8'd255, 8'd255, 8'd255}), 0, '0});
    vecs.push_back('{pixel_t'({8'd1, 8'd0, 8'd1, 8'd128}), 0, '0});
    vecs.push_back('{pixel_t'({8'd128, 8'd127, 8'd64, 8'd200}), 0, '0});
    vecs.push_back('{pixel_t'({8'd3, 8'd2, 8'd1, 8'd3}), 0, '0});
    vecs.push_back('{pixel_t'({8'd170, 8'h55, 8'haa, 8'h55}), 0, '0});
    foreach (vecs[i]) begin
      v = vecs[i];
      if (v.exp_valid) begin
        chk = filter_pixel(v.pix);
        if (chk !== v.exp) begin
          $error("table row %0d expected %h model %h", i, v.exp, chk);
          errors++;
        end
      end
      send_pixel(v.pix);
    end
    wait_drained();

    // Extreme matrix: most positive / negative lanes, offsets at limits
    write_reg(REG_RED_ROW, 64'h7fff_7fff_7fff_7fff);
    write_reg(REG_GREEN_ROW, 64'h8000_8000_8000_8000);
    write_reg(REG_BLUE_ROW, 64'hffff_0001_8000_7fff);
    write_reg(REG_OFFSETS, 64'h8000_7fff_0000_ffff);
    write_reg(REG_OPAQUE, 64'hffff_ffff_ffff_fffe);
    send_pixel(pixel_t'({8'd255, 8'd255, 8'd255, 8'd255}));
    send_pixel(pixel_t'({8'd0, 8'd255, 8'd0, 8'd255}));
    send_pixel(pixel_t'({8'd7, 8'd200, 8'd1, 8'd0}));
    wait_drained();
    write_reg(REG_OPAQUE, 64'h1);
    send_pixel(pixel_t'({8'd255, 8'd0, 8'd0, 8'd0}));
    send_pixel(pixel_t'({8'd9, 8'd255, 8'd128, 8'd1}));
    wait_drained();

    // Random setups; first and third are opaque with an identity alpha row
    for (setup = 0; setup < 7; setup++) begin
      for (int i = 0; i < 3; i++)
        write_reg(cfg_reg_e'(REG_RED_ROW + i),
                  (setup == 6) ? rand64() :
                  {rand_coef(), rand_coef(), rand_coef(), rand_coef()});
      if (setup == 0 || setup == 2)
        write_reg(REG_ALPHA_ROW, 64'h1 << (FracBits + 48));
      else
        write_reg(REG_ALPHA_ROW, (setup == 6) ? rand64() :
                  {rand_coef(), rand_coef(), rand_coef(), rand_coef()});
      write_reg(REG_OFFSETS, (setup == 6) ? rand64() :
                {(setup == 0 || setup == 2) ? 16'h0000 :
                   16'(int'($urandom_range(0, 32768)) - 16384),
                 16'(int'($urandom_range(0, 32768)) - 16384),
                 16'(int'($urandom_range(0, 32768)) - 16384),
                 (setup == 0) ? 16'h0000 : 16'(int'($urandom_range(0, 2048)) - 1024)});
      write_reg(REG_OPAQUE, (setup % 2 == 0) ? 64'h1 : 64'h0);
      for (int n = 0; n < 100; n++) begin
        p = $urandom();
        // mostly valid premultiplied pixels unless opaque, some invalid or zero alpha
        if ($urandom_range(0, 3) != 0 && !opaque_src) begin
          p.r = chan_t'($urandom_range(0, p.a));
          p.g = chan_t'($urandom_range(0, p.a));
          p.b = chan_t'($urandom_range(0, p.a));
        end
        if ($urandom_range(0, 15) == 0) p.a = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
        send_pixel(p);
      end
      wait_drained();
    end

    $display("Covered %0d pixels in, %0d out, over reset, extreme and 7 random setups",
             words_in, words_out);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
